// ----- design/jlrv_pkg.sv -----
// Shared constants, command codes and status struct for the reachable
// velocity block. No dependencies.
package jlrv_pkg;

    localparam int BISECT_STEPS = 32;
    localparam int FRAC_BITS    = 16;
    localparam int STEP_W       = $clog2(BISECT_STEPS);

    localparam logic [31:0] MARGIN_DIV  = 32'd1000000;
    localparam logic [31:0] MARGIN_BIAS = 32'd999999;
    // 1e6 = 64 * 15625: the biased length is shifted down by 6, then
    // multiplied by ceil(2^41 / 15625) and the product taken from bit 41 up
    localparam logic [27:0] MARGIN_RECIP = 28'd140737489;

    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NONE      = 5'd0;
    localparam cmd_t CMD_LOAD      = 5'd1;
    localparam cmd_t CMD_MARGIN    = 5'd2;
    localparam cmd_t CMD_USABLE    = 5'd3;
    localparam cmd_t CMD_MUL_AA    = 5'd4;
    localparam cmd_t CMD_THR       = 5'd5;
    localparam cmd_t CMD_SET_THR   = 5'd6;
    localparam cmd_t CMD_AJ        = 5'd7;
    localparam cmd_t CMD_SET_AJ    = 5'd8;
    localparam cmd_t CMD_LOW_INIT  = 5'd9;
    localparam cmd_t CMD_SET_MID   = 5'd10;
    localparam cmd_t CMD_DIV_DVJ   = 5'd11;
    localparam cmd_t CMD_DIV_DVA   = 5'd12;
    localparam cmd_t CMD_SQRT      = 5'd13;
    localparam cmd_t CMD_SET_DUR   = 5'd14;
    localparam cmd_t CMD_MUL_LO    = 5'd15;
    localparam cmd_t CMD_MUL_HI    = 5'd16;
    localparam cmd_t CMD_ACC_HI    = 5'd17;
    localparam cmd_t CMD_DECIDE    = 5'd18;
    localparam cmd_t CMD_RES_START = 5'd19;
    localparam cmd_t CMD_RES_CAP   = 5'd20;
    localparam cmd_t CMD_RES_LOW   = 5'd21;
    localparam cmd_t CMD_EMIT      = 5'd22;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic sqrt_done;
        logic limits_bad;
        logic cap_le_start;
        logic dv_zero;
        logic tri_sel;
        logic fits;
    } status_t;

endpackage

// ----- design/jlrv_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle. Uses jlrv_pkg.
module jlrv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic [jlrv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [31:0]                    rem_reg, rem_next;
    logic [63:0]                    quo_reg, quo_next;
    logic [31:0]                    dsr_reg, dsr_next;
    logic [32:0]                    shifted;
    logic                           ge;

    assign shifted = {rem_reg, quo_reg[63]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next  = jlrv_pkg::DIV_CNT_W'(jlrv_pkg::DIV_STEPS);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == jlrv_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/jlrv_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit operand, one result bit
// per cycle. Uses jlrv_pkg.
module jlrv_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [31:0] root
);

    logic [jlrv_pkg::SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [63:0]                     x_reg, x_next;
    logic [33:0]                     rem_reg, rem_next;
    logic [31:0]                     root_reg, root_next;
    logic [35:0]                     r2;
    logic [33:0]                     trial;
    logic                            ge;

    assign r2    = {rem_reg, x_reg[63:62]};
    assign trial = {root_reg, 2'b01};
    assign ge    = r2 >= {2'b00, trial};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            cnt_next  = jlrv_pkg::SQRT_CNT_W'(jlrv_pkg::SQRT_STEPS);
            busy_next = 1'b1;
            x_next    = operand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 34'(r2 - {2'b00, trial}) : r2[33:0];
            root_next = {root_reg[30:0], ge};
            x_next    = {x_reg[61:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == jlrv_pkg::SQRT_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- design/jlrv_datapath.sv -----
// Datapath: operand and bisection registers, shared divider and square
// root, one 32x32 multiplier, result and output registers. Uses jlrv_pkg.
module jlrv_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  jlrv_pkg::cmd_t         cmd,
    output jlrv_pkg::status_t      status,
    input  logic [31:0]            start_speed,
    input  logic [31:0]            speed_cap,
    input  logic [31:0]            segment_length,
    input  logic [31:0]            accel_limit,
    input  logic [31:0]            jerk_limit,
    output logic [31:0]            reachable_speed,
    output logic                   reached_cap,
    output logic                   limits_invalid
);

    localparam logic [63:0] MAX64 = {64{1'b1}};

    logic [31:0] start_reg, cap_reg, len_reg, a_reg, j_reg;
    logic [31:0] mid_reg, low_reg, high_reg, usable_reg, res_reg;
    logic        inv_reg;
    logic [13:0] margin_reg;
    logic [63:0] thr_reg, aj_reg, dur_reg, mul_reg;
    logic [95:0] acc_reg;
    logic [31:0] out_speed_reg;
    logic        out_cap_reg, out_inv_reg;

    logic [31:0] dv;
    logic [63:0] dv_sh;
    logic [32:0] speed_sum;
    logic [31:0] mean;
    logic        tri_sel;
    logic        dist_ok;

    logic        div_start, div_busy, div_done;
    logic [63:0] div_dvd, div_q;
    logic [31:0] div_dsr;
    logic        sqrt_done;
    logic [31:0] sqrt_root;
    logic [63:0] sqrt_op;

    logic [32:0] margin_num;
    logic [54:0] margin_prod;
    logic [13:0] margin_q;
    logic [31:0] usable;
    logic [31:0] mul_x, mul_y;
    logic [64:0] trap_sum;
    logic [63:0] dur_new;

    assign dv        = mid_reg - start_reg;
    assign dv_sh     = {32'd0, dv} << jlrv_pkg::FRAC_BITS;
    assign speed_sum = {1'b0, start_reg} + {1'b0, mid_reg};
    assign mean      = speed_sum[32:1];
    assign tri_sel   = {32'd0, dv} <= thr_reg;

    // far past the usable length once the product saturates
    assign dist_ok = (acc_reg < {32'd0, MAX64})
                     && ((acc_reg >> jlrv_pkg::FRAC_BITS) <= {64'd0, usable_reg});

    // margin is ceil(len / 1e6), at least one LSB; reciprocal multiply,
    // exact for every 32-bit length
    assign margin_num  = {1'b0, len_reg} + {1'b0, jlrv_pkg::MARGIN_BIAS};
    assign margin_prod = 55'(margin_num[32:6]) * 55'(jlrv_pkg::MARGIN_RECIP);
    assign margin_q    = margin_prod[54:41];
    assign usable = (len_reg > {18'd0, margin_reg}) ? (len_reg - {18'd0, margin_reg}) : 32'd0;

    always_comb
    begin
        div_start = 1'b1;
        div_dvd   = dv_sh;
        div_dsr   = j_reg;
        case (cmd)
            jlrv_pkg::CMD_THR:
            begin
                div_dvd = mul_reg;
            end
            jlrv_pkg::CMD_AJ:
            begin
                div_dvd = {32'd0, a_reg} << jlrv_pkg::FRAC_BITS;
            end
            jlrv_pkg::CMD_DIV_DVJ:
            begin
                div_dvd = dv_sh;
            end
            jlrv_pkg::CMD_DIV_DVA:
            begin
                div_dsr = a_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    jlrv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // saturating left shift of the quotient
    assign sqrt_op = ((div_q >> (64 - jlrv_pkg::FRAC_BITS)) != 64'd0)
                     ? MAX64 : (div_q << jlrv_pkg::FRAC_BITS);

    jlrv_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd == jlrv_pkg::CMD_SQRT),
        .operand (sqrt_op),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign trap_sum = {1'b0, div_q} + {1'b0, aj_reg};
    assign dur_new  = tri_sel ? {31'd0, sqrt_root, 1'b0}
                              : (trap_sum[64] ? MAX64 : trap_sum[63:0]);

    always_comb
    begin
        mul_x = mean;
        mul_y = dur_reg[31:0];
        case (cmd)
            jlrv_pkg::CMD_MUL_AA:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            jlrv_pkg::CMD_MUL_HI:
            begin
                mul_y = dur_reg[63:32];
            end
            default:
            begin
                mul_y = dur_reg[31:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            jlrv_pkg::CMD_LOAD:
            begin
                start_reg <= start_speed;
                cap_reg   <= speed_cap;
                len_reg   <= segment_length;
                a_reg     <= accel_limit;
                j_reg     <= jerk_limit;
                mid_reg   <= speed_cap;
            end
            jlrv_pkg::CMD_MARGIN:    margin_reg <= (margin_q == 14'd0) ? 14'd1 : margin_q;
            jlrv_pkg::CMD_USABLE:    usable_reg <= usable;
            jlrv_pkg::CMD_MUL_AA:    mul_reg    <= 64'(mul_x) * 64'(mul_y);
            jlrv_pkg::CMD_SET_THR:   thr_reg    <= div_q;
            jlrv_pkg::CMD_SET_AJ:    aj_reg     <= div_q;
            jlrv_pkg::CMD_LOW_INIT:
            begin
                low_reg  <= start_reg;
                high_reg <= cap_reg;
            end
            jlrv_pkg::CMD_SET_MID:   mid_reg <= low_reg + ((high_reg - low_reg) >> 1);
            jlrv_pkg::CMD_SET_DUR:   dur_reg <= dur_new;
            jlrv_pkg::CMD_MUL_LO:    mul_reg <= 64'(mul_x) * 64'(mul_y);
            jlrv_pkg::CMD_MUL_HI:
            begin
                mul_reg <= 64'(mul_x) * 64'(mul_y);
                acc_reg <= {32'd0, mul_reg};
            end
            jlrv_pkg::CMD_ACC_HI:    acc_reg <= acc_reg + {mul_reg, 32'd0};
            jlrv_pkg::CMD_DECIDE:
            begin
                if (status.fits)
                begin
                    low_reg <= mid_reg;
                end
                else
                begin
                    high_reg <= mid_reg;
                end
            end
            jlrv_pkg::CMD_RES_START:
            begin
                res_reg <= start_reg;
                inv_reg <= 1'b1;
            end
            jlrv_pkg::CMD_RES_CAP:
            begin
                res_reg <= cap_reg;
                inv_reg <= 1'b0;
            end
            jlrv_pkg::CMD_RES_LOW:
            begin
                res_reg <= low_reg;
                inv_reg <= 1'b0;
            end
            jlrv_pkg::CMD_EMIT:
            begin
                out_speed_reg <= res_reg;
                out_cap_reg   <= (res_reg == cap_reg);
                out_inv_reg   <= inv_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_busy     = div_busy;
    assign status.div_done     = div_done;
    assign status.sqrt_done    = sqrt_done;
    assign status.limits_bad   = (a_reg == 32'd0) || (j_reg == 32'd0);
    assign status.cap_le_start = cap_reg <= start_reg;
    assign status.dv_zero      = dv == 32'd0;
    assign status.tri_sel      = tri_sel;
    assign status.fits         = (dv == 32'd0) || dist_ok;

    assign reachable_speed = out_speed_reg;
    assign reached_cap     = out_cap_reg;
    assign limits_invalid  = out_inv_reg;

endmodule

// ----- design/jlrv_ctrl.sv -----
// Sequencer for the reachable velocity search: setup, full-change test,
// bisection and result hand-off. Uses jlrv_pkg.
module jlrv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output jlrv_pkg::cmd_t    cmd,
    input  jlrv_pkg::status_t status
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_MARGIN = 5'd2;
    localparam logic [4:0] S_AA     = 5'd3;
    localparam logic [4:0] S_THR    = 5'd4;
    localparam logic [4:0] S_THR_W  = 5'd5;
    localparam logic [4:0] S_AJ     = 5'd6;
    localparam logic [4:0] S_AJ_W   = 5'd7;
    localparam logic [4:0] S_EV     = 5'd8;
    localparam logic [4:0] S_DIV_W  = 5'd9;
    localparam logic [4:0] S_SQRT_W = 5'd10;
    localparam logic [4:0] S_MLO    = 5'd11;
    localparam logic [4:0] S_MHI    = 5'd12;
    localparam logic [4:0] S_ACC    = 5'd13;
    localparam logic [4:0] S_DEC    = 5'd14;
    localparam logic [4:0] S_RESL   = 5'd15;
    localparam logic [4:0] S_MID    = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0]                   state_reg, state_next;
    logic                         full_reg, full_next;
    logic [jlrv_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        full_next  = full_reg;
        step_next  = step_reg;
        cmd        = jlrv_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = jlrv_pkg::CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.limits_bad)
                begin
                    cmd        = jlrv_pkg::CMD_RES_START;
                    state_next = S_DONE;
                end
                else if (status.cap_le_start)
                begin
                    cmd        = jlrv_pkg::CMD_RES_CAP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = jlrv_pkg::CMD_MARGIN;
                    full_next  = 1'b1;
                    state_next = S_MARGIN;
                end
            end
            S_MARGIN:
            begin
                cmd        = jlrv_pkg::CMD_USABLE;
                state_next = S_AA;
            end
            S_AA:
            begin
                cmd        = jlrv_pkg::CMD_MUL_AA;
                state_next = S_THR;
            end
            S_THR:
            begin
                cmd        = jlrv_pkg::CMD_THR;
                state_next = S_THR_W;
            end
            S_THR_W:
            begin
                if (status.div_done)
                begin
                    cmd        = jlrv_pkg::CMD_SET_THR;
                    state_next = S_AJ;
                end
            end
            S_AJ:
            begin
                cmd        = jlrv_pkg::CMD_AJ;
                state_next = S_AJ_W;
            end
            S_AJ_W:
            begin
                if (status.div_done)
                begin
                    cmd        = jlrv_pkg::CMD_SET_AJ;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                if (status.dv_zero)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    cmd        = status.tri_sel ? jlrv_pkg::CMD_DIV_DVJ : jlrv_pkg::CMD_DIV_DVA;
                    state_next = S_DIV_W;
                end
            end
            S_DIV_W:
            begin
                if (status.div_done)
                begin
                    if (status.tri_sel)
                    begin
                        cmd        = jlrv_pkg::CMD_SQRT;
                        state_next = S_SQRT_W;
                    end
                    else
                    begin
                        cmd        = jlrv_pkg::CMD_SET_DUR;
                        state_next = S_MLO;
                    end
                end
            end
            S_SQRT_W:
            begin
                if (status.sqrt_done)
                begin
                    cmd        = jlrv_pkg::CMD_SET_DUR;
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd        = jlrv_pkg::CMD_MUL_LO;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd        = jlrv_pkg::CMD_MUL_HI;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd        = jlrv_pkg::CMD_ACC_HI;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (full_reg)
                begin
                    if (status.fits)
                    begin
                        cmd        = jlrv_pkg::CMD_RES_CAP;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd        = jlrv_pkg::CMD_LOW_INIT;
                        full_next  = 1'b0;
                        step_next  = '0;
                        state_next = S_MID;
                    end
                end
                else
                begin
                    cmd = jlrv_pkg::CMD_DECIDE;
                    if (step_reg == jlrv_pkg::STEP_W'(jlrv_pkg::BISECT_STEPS - 1))
                    begin
                        state_next = S_RESL;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_MID;
                    end
                end
            end
            S_RESL:
            begin
                cmd        = jlrv_pkg::CMD_RES_LOW;
                state_next = S_DONE;
            end
            S_MID:
            begin
                cmd        = jlrv_pkg::CMD_SET_MID;
                state_next = S_EV;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd        = jlrv_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd == jlrv_pkg::CMD_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == jlrv_pkg::CMD_THR || cmd == jlrv_pkg::CMD_AJ
         || cmd == jlrv_pkg::CMD_DIV_DVJ || cmd == jlrv_pkg::CMD_DIV_DVA)
        |-> !status.div_busy)
        else $error("divider restarted while busy");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == jlrv_pkg::CMD_EMIT) |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote an item still waiting");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == jlrv_pkg::CMD_EMIT) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("emitted item not shown");
`endif

endmodule

// ----- design/jerk_limited_reachable_velocity_core.sv -----
// Top level of the jerk-limited reachable velocity block.
// Uses jlrv_pkg, jlrv_ctrl, jlrv_datapath (with jlrv_div and jlrv_sqrt).
//
// Input channel: in_valid / in_stall with five Q16.16 fields. An item is
// taken when in_valid is high and in_stall low; in_stall is high from the
// cycle after acceptance until the item's result sits in the output
// register, so one item is worked on at a time.
// Output channel: out_valid / out_stall with reachable_speed, reached_cap
// and limits_invalid. The output register lets the next item be accepted
// and processed while the previous result waits; a stalled result holds.
// Zero limits or a cap at or below the start speed go from the checks
// straight to the result. Otherwise the full change is tested and, if it
// does not fit, 32 bisection steps follow; a step whose midpoint equals
// the start speed skips the distance evaluation.
// Each distance evaluation uses a divide on the shared bit-serial divider,
// a square root in the triangular case and a split multiply; the setup takes
// the margin by a reciprocal multiply and uses two divides (a*a/j, a/j).
// Reset: clears the sequencer and the output valid; no item is held.
// If the receiver stalls, the finished result waits in the sequencer's final
// state and no further item is taken until it moves into the output register.
module jerk_limited_reachable_velocity_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] start_speed,
    input  logic [31:0] speed_cap,
    input  logic [31:0] segment_length,
    input  logic [31:0] accel_limit,
    input  logic [31:0] jerk_limit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] reachable_speed,
    output logic        reached_cap,
    output logic        limits_invalid
);

    jlrv_pkg::cmd_t    cmd;
    jlrv_pkg::status_t status;

    // sequencer: handshakes and command stream
    jlrv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic, shared units and output register
    jlrv_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .start_speed     (start_speed),
        .speed_cap       (speed_cap),
        .segment_length  (segment_length),
        .accel_limit     (accel_limit),
        .jerk_limit      (jerk_limit),
        .reachable_speed (reachable_speed),
        .reached_cap     (reached_cap),
        .limits_invalid  (limits_invalid)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for jerk_limited_reachable_velocity_core: a bursty driver,
// a stalling receiver and an S-curve bisection predictor that checks each result.
// Needs jlrv_pkg and the block's RTL only.
module tb_top;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] cap;
        logic [31:0] len;
        logic [31:0] acc;
        logic [31:0] jrk;
    } request_t;

    typedef struct packed {
        logic [31:0] speed;
        logic        at_cap;
        logic        bad_limits;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] start_speed = '0;
    logic [31:0] speed_cap = '0;
    logic [31:0] segment_length = '0;
    logic [31:0] accel_limit = '0;
    logic [31:0] jerk_limit = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] reachable_speed;
    logic reached_cap;
    logic limits_invalid;

    request_t pending_requests[$];
    answer_t  awaited_answers[$];
    int       error_count = 0;
    logic     took_item = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_pct = 0;
    int       stall_timer = 0;

    always #4 clk = ~clk;

    jerk_limited_reachable_velocity_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_speed    (start_speed),
        .speed_cap      (speed_cap),
        .segment_length (segment_length),
        .accel_limit    (accel_limit),
        .jerk_limit     (jerk_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reachable_speed(reachable_speed),
        .reached_cap    (reached_cap),
        .limits_invalid (limits_invalid)
    );

    // --- saturating 64-bit helpers ---
    function automatic logic [63:0] clamp_mul(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        p = 128'(x) * 128'(y);
        return (p[127:64] != 0) ? ALL_ONES : p[63:0];
    endfunction

    function automatic logic [63:0] clamp_shl(logic [63:0] x, int sh);
        if (sh == 0)
            return x;
        return (x > (ALL_ONES >> sh)) ? ALL_ONES : (x << sh);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Distance of a jerk-limited speed-up from v0 to v1.
    function automatic logic [63:0] s_curve_distance(logic [63:0] v0, logic [63:0] v1,
                                                     logic [63:0] a, logic [63:0] j);
        logic [63:0] dv;
        logic [63:0] thr;
        logic [63:0] dur;
        logic [63:0] sum;
        logic [63:0] p;
        dv = v1 - v0;
        if (dv == 0)
            return 64'd0;
        thr = (a * a) / j;
        if (dv <= thr)
            // triangular: 2 * sqrt(dv / j)
            dur = clamp_mul(64'd2, int_sqrt(clamp_shl((dv << jlrv_pkg::FRAC_BITS) / j,
                                                      jlrv_pkg::FRAC_BITS)));
        else
        begin
            // trapezoidal: dv / a + a / j
            sum = ((dv << jlrv_pkg::FRAC_BITS) / a) + ((a << jlrv_pkg::FRAC_BITS) / j);
            dur = (sum < ((dv << jlrv_pkg::FRAC_BITS) / a)) ? ALL_ONES : sum;
        end
        p = clamp_mul((v0 + v1) >> 1, dur);
        return (p == ALL_ONES) ? ALL_ONES : (p >> jlrv_pkg::FRAC_BITS);
    endfunction

    function automatic answer_t reachable_of(request_t r);
        answer_t ans;
        logic [63:0] margin;
        logic [63:0] usable;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] res;
        ans.bad_limits = 1'b0;
        if (r.acc == 0 || r.jrk == 0)
        begin
            res = 64'(r.v0);
            ans.bad_limits = 1'b1;
        end
        else if (r.cap <= r.v0)
            res = 64'(r.cap);
        else
        begin
            margin = (64'(r.len) + 64'(jlrv_pkg::MARGIN_BIAS)) / 64'(jlrv_pkg::MARGIN_DIV);
            if (margin < 64'd1)
                margin = 64'd1;
            usable = (64'(r.len) > margin) ? 64'(r.len) - margin : 64'd0;
            if (s_curve_distance(64'(r.v0), 64'(r.cap), 64'(r.acc), 64'(r.jrk)) <= usable)
                res = 64'(r.cap);
            else
            begin
                lo = 64'(r.v0);
                hi = 64'(r.cap);
                for (int k = 0; k < jlrv_pkg::BISECT_STEPS; k++)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (s_curve_distance(64'(r.v0), mid, 64'(r.acc), 64'(r.jrk)) <= usable)
                        lo = mid;
                    else
                        hi = mid;
                end
                res = lo;
            end
        end
        ans.speed = res[31:0];
        ans.at_cap = (res == 64'(r.cap));
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // --- driver: bursts of items with random gaps, changes on the falling edge ---
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !took_item)
                ; // hold the stalled item
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                in_valid       <= 1'b1;
                start_speed    <= pending_requests[0].v0;
                speed_cap      <= pending_requests[0].cap;
                segment_length <= pending_requests[0].len;
                accel_limit    <= pending_requests[0].acc;
                jerk_limit     <= pending_requests[0].jrk;
                void'(pending_requests.pop_front());
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 6);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                end
            end
            else
                in_valid <= 1'b0;

            // receiver: stall level is redrawn whenever stall_timer runs out
            if (stall_timer == 0)
            begin
                stall_timer <= $urandom_range(50, 3000);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    2: stall_pct <= 70;
                    default: stall_pct <= 95;
                endcase
            end
            else
                stall_timer <= stall_timer - 1;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // --- monitor: acceptance and result checks on the rising edge ---
    always @(posedge clk)
    begin
        took_item <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            awaited_answers = {awaited_answers,
                               reachable_of({start_speed, speed_cap, segment_length,
                                             accel_limit, jerk_limit})};
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_answers.size() == 0)
            begin
                report_mismatch("unexpected result", reachable_speed, 32'd0);
            end
            else
            begin
                if (reachable_speed !== awaited_answers[0].speed)
                    report_mismatch("reachable_speed", reachable_speed,
                                    awaited_answers[0].speed);
                if (reached_cap !== awaited_answers[0].at_cap)
                    report_mismatch("reached_cap", 32'(reached_cap),
                                    32'(awaited_answers[0].at_cap));
                if (limits_invalid !== awaited_answers[0].bad_limits)
                    report_mismatch("limits_invalid", 32'(limits_invalid),
                                    32'(awaited_answers[0].bad_limits));
                void'(awaited_answers.pop_front());
            end
        end
    end

    function automatic logic [31:0] rand_sized();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(0, 32'h000F_FFFF);
            2: return $urandom_range(0, 32'h0FFF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_request(logic [31:0] v0, logic [31:0] cap, logic [31:0] len,
                                 logic [31:0] acc, logic [31:0] jrk);
        request_t r;
        r = '{v0: v0, cap: cap, len: len, acc: acc, jrk: jrk};
        pending_requests = {pending_requests, r};
    endtask

    initial
    begin
        request_t r;
        int pick;
        // directed: zero limits, cap at/below start, extremes, both profiles, saturation
        queue_request(32'h0001_0000, 32'h0002_0000, 32'h0010_0000, 32'd0, 32'h0001_0000);
        queue_request(32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 32'd0);
        queue_request(32'hFFFF_FFFF, 32'h0000_0005, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_request(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h0001_0000);
        queue_request(32'h0005_0000, 32'h0005_0000, 32'd0, 32'h0001_0000, 32'h0001_0000);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        queue_request(32'd0, 32'h0001_0000, 32'h0100_0000, 32'h0001_0000, 32'h0001_0000);
        queue_request(32'd0, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'h0001_0000);
        queue_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        queue_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        queue_request(32'd0, 32'd1, 32'd1, 32'd1, 32'd1);
        queue_request(32'd0, 32'd1, 32'd2, 32'd1, 32'd1);
        queue_request(32'h0010_0000, 32'h0020_0000, 32'h0100_0000, 32'h0004_0000,
                      32'h0000_1000);
        queue_request(32'h0010_0000, 32'h0020_0000, 32'h0100_0000, 32'h0000_1000,
                      32'h0100_0000);
        queue_request(32'h1234_5678, 32'h8765_4321, 32'h0000_0100, 32'h00A0_0000,
                      32'h0000_0003);
        queue_request(32'd0, 32'h0000_0002, 32'h000F_4240, 32'h0000_0001, 32'h0000_0001);
        // random: mostly requests needing a real search, some fits and trivial ones
        for (int n = 0; n < 300; n++)
        begin
            pick = $urandom_range(0, 19);
            r.v0  = rand_sized();
            r.cap = rand_sized();
            r.len = rand_sized();
            r.acc = rand_sized();
            r.jrk = rand_sized();
            if (pick == 0)
                r.acc = '0;
            else if (pick == 1)
                r.jrk = '0;
            else if (pick < 4)
                r.cap = r.v0 - $urandom_range(0, 3);
            else
            begin
                if (r.cap <= r.v0)
                    {r.v0, r.cap} = {r.cap, r.v0};
                if (r.acc == 0)
                    r.acc = 1;
                if (r.jrk == 0)
                    r.jrk = 1;
                if (pick < 8)
                    r.len = $urandom();
            end
            pending_requests = {pending_requests, r};
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !in_valid && awaited_answers.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0 && awaited_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Timeout: far beyond the slowest run with every item searched and heavy stalls.
    initial
    begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/jlrv_pkg.sv
design/jlrv_div.sv
design/jlrv_sqrt.sv
design/jlrv_datapath.sv
design/jlrv_ctrl.sv
design/jerk_limited_reachable_velocity_core.sv
sim/tb_top.sv
